FILE: hdl/sdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdl_pkg;

  // field widths
  localparam int MODE_W = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  localparam int CAPACITY_DEF = 16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  list_length;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic run;
    logic ins;
    logic del;
    logic srch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_descending_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted list of up to CAPACITY signed 32-bit values, largest first.
// Input channel in_valid / in_stall / in_data carries one operation per transfer:
// insert a value (position only checked), delete at a 1-based position, or
// search for a value. Output channel out_valid / out_stall / out_data returns
// exactly one result per operation: status, first match position, length.
// After the input transfer, a run state lets every cell of the compare-and-shift
// chain act at once; then a resolve state loads the match encoder result into
// the output register and raises out_valid. The block takes one operation at
// a time; in_stall is high while an operation is in flight.
// When out_stall holds a result, the next operation is still accepted and
// runs through the chain; it then waits in the encoder step until the
// output register frees. Reset empties the list and clears out_valid; no
// clearing pass is needed, held values are only read below the length.
module sorted_descending_list #(
  parameter int CAPACITY = sdl_pkg::CAPACITY_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire sdl_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output sdl_pkg::out_item_t     out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > sdl_pkg::POS_W) ? CNT_W : sdl_pkg::POS_W) + 1;
  localparam int LW    = sdl_pkg::LEN_W;
  localparam int PW    = sdl_pkg::POS_W;
  localparam int VW    = sdl_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_RUN     = 3'b010,
    S_RESOLVE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  sdl_pkg::in_item_t   op_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sdl_pkg::STAT_W-1:0] status_r, status_nxt;
  sdl_pkg::out_item_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  sdl_pkg::cell_ctrl_t ctrl;

  logic [CMP_W-1:0]    pos_w, cnt_w;
  logic                is_ins, is_del, is_srch;

  logic [VW-1:0]       entry  [CAPACITY];
  logic                take   [CAPACITY];
  logic                eq     [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [CNT_W-1:0]    hit_idx;
  logic                hit_any;

  assign pos_w   = CMP_W'(op_r.position);
  assign cnt_w   = CMP_W'(cnt_r);
  assign is_ins  = op_r.mode == sdl_pkg::MODE_INSERT;
  assign is_del  = op_r.mode == sdl_pkg::MODE_DELETE;
  assign is_srch = op_r.mode == sdl_pkg::MODE_SEARCH;

  // check the operation during the run cycle
  always_comb begin
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    ctrl       = '0;
    if (state_r == S_RUN) begin
      ctrl.run   = 1'b1;
      ctrl.srch  = is_srch;
      status_nxt = sdl_pkg::ST_OK;
      if (is_ins) begin
        if (cnt_r == CNT_W'(CAPACITY)) begin
          status_nxt = sdl_pkg::ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          status_nxt = sdl_pkg::ST_RANGE;
        end else begin
          ctrl.ins = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end else if (is_del) begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status_nxt = sdl_pkg::ST_RANGE;
        end else begin
          ctrl.del = 1'b1;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // chain of compare-and-shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] l_entry, r_entry;
    logic          l_take, l_eq;
    if (i == 0) begin : g_head
      assign l_entry = '0;
      assign l_take  = 1'b0;
      assign l_eq    = 1'b0;
    end else begin : g_body
      assign l_entry = entry[i-1];
      assign l_take  = take[i-1];
      assign l_eq    = eq[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = entry[i];
    end else begin : g_inner
      assign r_entry = entry[i+1];
    end
    sdl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .value       (op_r.value),
      .cnt         (cnt_r),
      .del_pos     (pos_w),
      .left_entry  (l_entry),
      .left_take   (l_take),
      .left_eq     (l_eq),
      .right_entry (r_entry),
      .entry       (entry[i]),
      .take        (take[i]),
      .eq          (eq[i]),
      .hit         (hits[i])
    );
  end

  sdl_encode #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_encode (
    .hits  (hits),
    .index (hit_idx),
    .any   (hit_any)
  );

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status         = status_r;
          out_nxt.found_position = '0;
          out_nxt.list_length    = LW'(cnt_r);
          if (is_srch) begin
            out_nxt.status = hit_any ? sdl_pkg::ST_OK : sdl_pkg::ST_NOTFOUND;
            if (hit_any) begin
              out_nxt.found_position = PW'(hit_idx + CNT_W'(1));
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_data;
    end
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hdl/sdl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sdl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5,
  parameter int CMP_W = 6
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire sdl_pkg::cell_ctrl_t            ctrl,
  input  wire logic signed [sdl_pkg::VAL_W-1:0] value,
  input  wire logic [CNT_W-1:0]               cnt,
  input  wire logic [CMP_W-1:0]               del_pos,
  input  wire logic [sdl_pkg::VAL_W-1:0]      left_entry,
  input  wire logic                           left_take,
  input  wire logic                           left_eq,
  input  wire logic [sdl_pkg::VAL_W-1:0]      right_entry,
  output logic [sdl_pkg::VAL_W-1:0]           entry,
  output logic                                take,
  output logic                                eq,
  output logic                                hit
);

  logic [sdl_pkg::VAL_W-1:0] entry_r, entry_nxt;
  logic                      hit_r, hit_nxt;
  logic                      occ, gt, shift_up;

  // local compares against the broadcast value
  assign occ      = CNT_W'(IDX) < cnt;
  assign gt       = value > $signed(entry_r);
  assign eq       = occ && (entry_r == value);
  // list is descending, so every free or smaller slot moves for an insert
  assign take     = !occ || gt;
  assign shift_up = CMP_W'(IDX + 1) >= del_pos;

  // next entry: hold, take from left neighbor, take new value, or take from right
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.run && ctrl.ins && take) begin
      entry_nxt = left_take ? left_entry : value;
    end else if (ctrl.run && ctrl.del && shift_up) begin
      entry_nxt = right_entry;
    end
  end

  // first match of a contiguous run of equal entries
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.run) begin
      hit_nxt = ctrl.srch && eq && !left_eq;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

`default_nettype wire

FILE: hdl/sdl_encode.sv
`timescale 1ns / 1ps
`default_nettype none

module sdl_encode #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  wire logic [CAPACITY-1:0] hits,
  output logic [CNT_W-1:0]         index,
  output logic                     any
);

  // hit vector is one-hot or zero, so an or of selected indexes gives the place
  always_comb begin
    index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      index = index | (hits[i] ? CNT_W'(i) : '0);
    end
  end

  assign any = |hits;

endmodule

`default_nettype wire

FILE: hdl/sdl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdl_checker #(
  parameter int CAPACITY = sdl_pkg::CAPACITY_DEF
) (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_stall,
  input wire                     out_valid,
  input wire                     out_stall,
  input wire sdl_pkg::out_item_t out_data
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one operation at a time: busy right after an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  // length never exceeds capacity; checked only while CAPACITY fits the 5-bit length field
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 31) || (int'(out_data.list_length) <= CAPACITY))
    else $error("list length above capacity");

  // a failed search reports no position
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sdl_pkg::ST_NOTFOUND |-> out_data.found_position == '0)
    else $error("position reported on a failed search");

endmodule

bind sorted_descending_list sdl_checker #(.CAPACITY(CAPACITY)) u_sdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
